// ===== rtl/led_blink_pattern_controller_core_macros.svh =====
`ifndef LED_BLINK_PATTERN_CONTROLLER_CORE_MACROS_SVH
`define LED_BLINK_PATTERN_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define LBPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbpc: same-cycle check failed");

`define LBPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbpc: next-cycle check failed");

`else

`define LBPC_ASSERT_NOW(label, clk, rst, ante, cons)

`define LBPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lbpc_pkg.sv =====
package lbpc_pkg;

   localparam int NUM_LEDS       = 4;
   localparam int TIMER_BITS_DEF = 16;
   localparam int PERIOD_BITS    = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STEP_BITS      = 4;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd50;
   localparam logic [NUM_LEDS-1:0]    ACTIVE_RESET = 4'hF;

   // LED channel slots driven by the two-LED pattern
   localparam int LED1_SLOT = 0;
   localparam int LED2_SLOT = 1;

   localparam logic [STEP_BITS-1:0] PAT_LEN_SHORT  = 4'd4;
   localparam logic [STEP_BITS-1:0] PAT_LEN_MEDIUM = 4'd6;
   localparam logic [STEP_BITS-1:0] PAT_LEN_LONG   = 4'd8;
   localparam logic [STEP_BITS-1:0] PAT_STEP_ONE   = 4'd1;
   localparam logic [STEP_BITS-1:0] PAT_STEP_TWO   = 4'd2;

   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_COMMAND = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      CMD_OFF           = 3'd0,
      CMD_ON            = 3'd1,
      CMD_BLINK_STOP    = 3'd2,
      CMD_BLINK_START   = 3'd3,
      CMD_PATTERN_START = 3'd4,
      CMD_PATTERN_STOP  = 3'd5
   } command_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLINK_PERIOD   = 2'd0,
      CSR_PATTERN_PERIOD = 2'd1,
      CSR_ACTIVE_HIGH    = 2'd2
   } csr_index_type;

   // pattern length chosen by the led index of a pattern start
   function automatic logic [STEP_BITS-1:0] pattern_length_of(input logic [1:0] sel);
      logic [STEP_BITS-1:0] len;
      case (sel)
         2'd0:    len = PAT_LEN_SHORT;
         2'd1:    len = PAT_LEN_MEDIUM;
         default: len = PAT_LEN_LONG;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/led_blink_pattern_controller_core.sv =====
// LED blink and pattern controller, four channels (LED1, LED2, LED3, error LED).
// Request channel (req_valid/req_ready): one beat is either a tick (req_func 0)
// or a command (req_func 1) with req_led_index and req_command.
// Response channel (rsp_valid/rsp_ready): exactly one beat per request beat,
// carrying pin levels, blink enables and the pattern-running flag after it.
// CSR port: csr_we writes csr_wdata into register csr_index at once
// (0 blink period, 1 pattern period, 2 active-high mask); write only when idle.
// The state update is done combinationally from the accepted beat, and the
// result lands in the response register at the same edge as the new state.
// Throughput is one beat per cycle while rsp_ready is high; the limit is the
// single response register. When the receiver stalls, req_ready drops until
// the held response is taken; the response holds unchanged meanwhile.
// Reset (synchronous, active high) clears all LEDs, blink and pattern state,
// sets pattern length to four and periods to 50 ticks, mask to all active high.
module led_blink_pattern_controller_core #(
   parameter int TIMER_BITS = lbpc_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [1:0]                          req_led_index,
   input  logic [2:0]                          req_command,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lbpc_pkg::NUM_LEDS-1:0]       rsp_led_pins,
   output logic [lbpc_pkg::NUM_LEDS-1:0]       rsp_blink_running,
   output logic                                rsp_pattern_running,
   input  logic                                csr_we,
   input  logic [lbpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbpc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lbpc_pkg::*;

`include "led_blink_pattern_controller_core_macros.svh"

   localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;

   logic [PERIOD_BITS-1:0] blink_period_ff;
   logic [PERIOD_BITS-1:0] pattern_period_ff;
   logic [NUM_LEDS-1:0]    active_high_ff;

   logic [NUM_LEDS-1:0]    lit_ff, lit_in;
   logic [NUM_LEDS-1:0]    blink_en_ff, blink_en_in;
   logic [TIMER_BITS-1:0]  blink_timer_ff [NUM_LEDS];
   logic [TIMER_BITS-1:0]  blink_timer_in [NUM_LEDS];
   logic [TIMER_BITS-1:0]  blink_inc [NUM_LEDS];
   logic                   pat_en_ff, pat_en_in;
   logic [TIMER_BITS-1:0]  pat_timer_ff, pat_timer_in;
   logic [TIMER_BITS-1:0]  pat_inc;
   logic [STEP_BITS-1:0]   pat_step_ff, pat_step_in;
   logic [STEP_BITS-1:0]   step_inc;
   logic                   pat_phase_ff, pat_phase_in;
   logic [STEP_BITS-1:0]   pat_len_ff, pat_len_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_LEDS-1:0]    rsp_pins_ff;
   logic [NUM_LEDS-1:0]    rsp_blink_ff;
   logic                   rsp_pattern_ff;

   logic                   req_accept;
   logic                   idle_timers_clear;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         blink_inc[i] = blink_timer_ff[i] + 1'b1;
      end
   end

   assign pat_inc  = pat_timer_ff + 1'b1;
   assign step_inc = pat_step_ff + 1'b1;

   // next state for one accepted beat
   always_comb begin
      lit_in       = lit_ff;
      blink_en_in  = blink_en_ff;
      for (int i = 0; i < NUM_LEDS; i++) begin
         blink_timer_in[i] = blink_timer_ff[i];
      end
      pat_en_in    = pat_en_ff;
      pat_timer_in = pat_timer_ff;
      pat_step_in  = pat_step_ff;
      pat_phase_in = pat_phase_ff;
      pat_len_in   = pat_len_ff;

      if (req_accept) begin
         if (func_type'(req_func) == FUNC_TICK) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
               if (blink_en_ff[i]) begin
                  if (CMP_BITS'(blink_inc[i]) >= CMP_BITS'(blink_period_ff)) begin
                     blink_timer_in[i] = '0;
                     lit_in[i]         = !lit_ff[i];
                  end else begin
                     blink_timer_in[i] = blink_inc[i];
                  end
               end
            end
            if (pat_en_ff) begin
               if (CMP_BITS'(pat_inc) >= CMP_BITS'(pattern_period_ff)) begin
                  pat_timer_in = '0;
                  pat_phase_in = !pat_phase_ff;
                  if (step_inc == PAT_STEP_ONE || step_inc == PAT_STEP_TWO) begin
                     lit_in[LED1_SLOT] = 1'b0;
                     lit_in[LED2_SLOT] = !pat_phase_ff;
                     pat_step_in       = step_inc;
                  end else begin
                     lit_in[LED1_SLOT] = !pat_phase_ff;
                     lit_in[LED2_SLOT] = 1'b0;
                     pat_step_in       = (step_inc >= pat_len_ff) ? '0 : step_inc;
                  end
               end else begin
                  pat_timer_in = pat_inc;
               end
            end
         end else begin
            case (command_type'(req_command))
               CMD_OFF: begin
                  lit_in[req_led_index] = 1'b0;
               end
               CMD_ON: begin
                  lit_in[req_led_index] = 1'b1;
               end
               CMD_BLINK_STOP: begin
                  blink_en_in[req_led_index]    = 1'b0;
                  blink_timer_in[req_led_index] = '0;
                  lit_in[req_led_index]         = 1'b0;
               end
               CMD_BLINK_START: begin
                  blink_en_in[req_led_index] = 1'b1;
               end
               CMD_PATTERN_START: begin
                  pat_step_in  = '0;
                  pat_timer_in = '0;
                  pat_phase_in = 1'b0;
                  pat_en_in    = 1'b1;
                  pat_len_in   = pattern_length_of(req_led_index);
               end
               CMD_PATTERN_STOP: begin
                  pat_en_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff   <= PERIOD_RESET;
         pattern_period_ff <= PERIOD_RESET;
         active_high_ff    <= ACTIVE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLINK_PERIOD:   blink_period_ff   <= csr_wdata[PERIOD_BITS-1:0];
            CSR_PATTERN_PERIOD: pattern_period_ff <= csr_wdata[PERIOD_BITS-1:0];
            CSR_ACTIVE_HIGH:    active_high_ff    <= csr_wdata[NUM_LEDS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff       <= '0;
         blink_en_ff  <= '0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            blink_timer_ff[i] <= '0;
         end
         pat_en_ff    <= 1'b0;
         pat_timer_ff <= '0;
         pat_step_ff  <= '0;
         pat_phase_ff <= 1'b0;
         pat_len_ff   <= PAT_LEN_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         lit_ff       <= lit_in;
         blink_en_ff  <= blink_en_in;
         for (int i = 0; i < NUM_LEDS; i++) begin
            blink_timer_ff[i] <= blink_timer_in[i];
         end
         pat_en_ff    <= pat_en_in;
         pat_timer_ff <= pat_timer_in;
         pat_step_ff  <= pat_step_in;
         pat_phase_ff <= pat_phase_in;
         pat_len_ff   <= pat_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with each accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pins_ff    <= lit_in ^ ~active_high_ff;
         rsp_blink_ff   <= blink_en_in;
         rsp_pattern_ff <= pat_en_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_led_pins        = rsp_pins_ff;
   assign rsp_blink_running   = rsp_blink_ff;
   assign rsp_pattern_running = rsp_pattern_ff;

   // a channel that is not blinking always has a cleared timer
   always_comb begin
      idle_timers_clear = 1'b1;
      for (int i = 0; i < NUM_LEDS; i++) begin
         if (!blink_en_ff[i] && blink_timer_ff[i] != '0) begin
            idle_timers_clear = 1'b0;
         end
      end
   end

   `LBPC_ASSERT_NOW(a_step_below_len, clock, reset, 1'b1, pat_step_ff < pat_len_ff)
   `LBPC_ASSERT_NOW(a_len_legal, clock, reset, 1'b1,
      pat_len_ff == PAT_LEN_SHORT || pat_len_ff == PAT_LEN_MEDIUM || pat_len_ff == PAT_LEN_LONG)
   `LBPC_ASSERT_NOW(a_idle_timer_clear, clock, reset, 1'b1, idle_timers_clear)
   `LBPC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff)

endmodule
